// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/cau_pkg.sv -----
package cau_pkg;

  localparam int DW   = 32;          // word width
  localparam int FB   = 16;          // fraction bits
  localparam int PW   = 2 * DW;      // product width
  localparam int SW   = PW + 1;      // width of a sum of two products
  localparam int NW   = SW + FB;     // dividend magnitude width
  localparam int QB   = DW + 1;      // quotient bits, one division cell each
  localparam int RW   = PW;          // remainder and divisor width
  localparam int SATW = PW + 2;      // width that every value is saturated from

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CNJ = 3'd4,
    OP_NEG = 3'd5
  } op_e;

  typedef logic signed [DW-1:0]   word_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [SW-1:0]   sum_t;
  typedef logic signed [SATW-1:0] sat_t;
  typedef logic [RW-1:0]          rem_t;
  typedef logic [QB-1:0]          quo_t;

  localparam word_t W_MAX   = {1'b0, {(DW-1){1'b1}}};
  localparam word_t W_MIN   = {1'b1, {(DW-1){1'b0}}};
  localparam sat_t  SAT_MAX = {{(SATW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam sat_t  SAT_MIN = ~SAT_MAX;

  // One step of the restoring divider.
  typedef struct packed {
    rem_t rem;   // partial remainder, below den unless the quotient overflows
    quo_t low;   // dividend bits still to be shifted in, MSB first
    quo_t quo;   // quotient bits found so far
    rem_t den;   // divisor |B|^2
  } cell_t;

  // Per-item data that travels beside the divider cells.
  typedef struct packed {
    op_e   op;
    word_t pre_re;
    word_t pre_im;
    logic  pre_ovf;
    logic  dz;
    logic  neg_re;
    logic  neg_im;
    logic  big_re;
    logic  big_im;
  } side_t;

  // Clamp a wide signed value to a word; the MSB of the result is the overflow flag.
  function automatic logic [DW:0] sat(input sat_t v);
    logic [DW:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, W_MAX};
    end else if (v < SAT_MIN) begin
      r = {1'b1, W_MIN};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

endpackage

// ----- design/cau_div_cell.sv -----
module cau_div_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  cau_pkg::cell_t  cell_i,
  output cau_pkg::cell_t  cell_o
);

  logic [cau_pkg::RW:0] trial;
  logic [cau_pkg::RW:0] diff;
  logic                 ge;
  cau_pkg::cell_t       cell_d;
  cau_pkg::cell_t       cell_q;

  always_comb begin
    trial = {cell_i.rem, cell_i.low[cau_pkg::QB-1]};
    diff  = trial - {1'b0, cell_i.den};
    ge    = trial >= {1'b0, cell_i.den};
    cell_d.rem = ge ? diff[cau_pkg::RW-1:0] : trial[cau_pkg::RW-1:0];
    cell_d.low = {cell_i.low[cau_pkg::QB-2:0], 1'b0};
    cell_d.quo = {cell_i.quo[cau_pkg::QB-2:0], ge};
    cell_d.den = cell_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- design/complex_arithmetic_unit.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o | req_type_i, a_re_i, a_im_i, b_re_i, b_im_i
// output   | out_valid_o/ out_ready_i| res_re_o, res_im_o, overflow_o, div_zero_o
//
// The block accepts one item per cycle while in_ready_o is high and passes each
// accepted item through one multiply stage, one combine stage, one setup stage,
// one restoring divider cell per quotient bit, and the output register.
// Every operation takes the same path, so results leave in input order.
// Reset clears only the valid bits; the data registers hold whatever they last held.
// When the output item waits, the whole pipeline holds and in_ready_o drops.
module complex_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    req_type_i,
  input  logic signed [cau_pkg::DW-1:0] a_re_i,
  input  logic signed [cau_pkg::DW-1:0] a_im_i,
  input  logic signed [cau_pkg::DW-1:0] b_re_i,
  input  logic signed [cau_pkg::DW-1:0] b_im_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [cau_pkg::DW-1:0] res_re_o,
  output logic signed [cau_pkg::DW-1:0] res_im_o,
  output logic                          overflow_o,
  output logic                          div_zero_o
);

  // One enable moves every stage. It is low only while a finished item waits
  // at the output and the consumer is not taking it.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------------
  // Stage A: the six products, and the finished result of the simple operations.
  // ---------------------------------------------------------------------------
  cau_pkg::op_e   op_a_d;
  cau_pkg::sat_t  simp_re, simp_im;
  logic [cau_pkg::DW:0] s_re, s_im;

  always_comb begin
    op_a_d  = cau_pkg::op_e'(req_type_i);
    simp_re = '0;
    simp_im = '0;
    unique case (req_type_i)
      cau_pkg::OP_ADD: begin
        simp_re = cau_pkg::sat_t'(a_re_i) + cau_pkg::sat_t'(b_re_i);
        simp_im = cau_pkg::sat_t'(a_im_i) + cau_pkg::sat_t'(b_im_i);
      end
      cau_pkg::OP_SUB: begin
        simp_re = cau_pkg::sat_t'(a_re_i) - cau_pkg::sat_t'(b_re_i);
        simp_im = cau_pkg::sat_t'(a_im_i) - cau_pkg::sat_t'(b_im_i);
      end
      cau_pkg::OP_CNJ: begin
        simp_re = cau_pkg::sat_t'(a_re_i);
        simp_im = -cau_pkg::sat_t'(a_im_i);
      end
      cau_pkg::OP_NEG: begin
        simp_re = -cau_pkg::sat_t'(a_re_i);
        simp_im = -cau_pkg::sat_t'(a_im_i);
      end
      default: begin
        // Multiply and divide are finished later; unused codes give zero.
        simp_re = '0;
        simp_im = '0;
      end
    endcase
    s_re = cau_pkg::sat(simp_re);
    s_im = cau_pkg::sat(simp_im);
  end

  logic           v_a_q;
  cau_pkg::op_e   op_a_q;
  cau_pkg::word_t pre_re_a_q, pre_im_a_q;
  logic           pre_ovf_a_q;
  cau_pkg::prod_t p_rr_q, p_ii_q, p_ri_q, p_ir_q, d_rr_q, d_ii_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_a_q      <= op_a_d;
      pre_re_a_q  <= s_re[cau_pkg::DW-1:0];
      pre_im_a_q  <= s_im[cau_pkg::DW-1:0];
      pre_ovf_a_q <= s_re[cau_pkg::DW] || s_im[cau_pkg::DW];
      p_rr_q      <= a_re_i * b_re_i;
      p_ii_q      <= a_im_i * b_im_i;
      p_ri_q      <= a_re_i * b_im_i;
      p_ir_q      <= a_im_i * b_re_i;
      d_rr_q      <= b_re_i * b_re_i;
      d_ii_q      <= b_im_i * b_im_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: combine products. A multiply is finished here; a divide leaves
  // its two signed numerators and the divisor |B|^2.
  // ---------------------------------------------------------------------------
  cau_pkg::sum_t  m_re, m_im, n_re_d, n_im_d;
  cau_pkg::rem_t  den_d;
  logic [cau_pkg::DW:0] ms_re, ms_im;

  always_comb begin
    m_re   = cau_pkg::sum_t'(p_rr_q) - cau_pkg::sum_t'(p_ii_q);
    m_im   = cau_pkg::sum_t'(p_ri_q) + cau_pkg::sum_t'(p_ir_q);
    n_re_d = cau_pkg::sum_t'(p_rr_q) + cau_pkg::sum_t'(p_ii_q);
    n_im_d = cau_pkg::sum_t'(p_ir_q) - cau_pkg::sum_t'(p_ri_q);
    den_d  = cau_pkg::rem_t'(d_rr_q) + cau_pkg::rem_t'(d_ii_q);
    // The arithmetic shift rounds the product toward minus infinity.
    ms_re  = cau_pkg::sat(cau_pkg::sat_t'(m_re >>> cau_pkg::FB));
    ms_im  = cau_pkg::sat(cau_pkg::sat_t'(m_im >>> cau_pkg::FB));
  end

  logic           v_b_q;
  cau_pkg::op_e   op_b_q;
  cau_pkg::word_t pre_re_b_q, pre_im_b_q;
  logic           pre_ovf_b_q;
  cau_pkg::sum_t  n_re_q, n_im_q;
  cau_pkg::rem_t  den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_b_q <= op_a_q;
      n_re_q <= n_re_d;
      n_im_q <= n_im_d;
      den_q  <= den_d;
      if (op_a_q == cau_pkg::OP_MUL) begin
        pre_re_b_q  <= ms_re[cau_pkg::DW-1:0];
        pre_im_b_q  <= ms_im[cau_pkg::DW-1:0];
        pre_ovf_b_q <= ms_re[cau_pkg::DW] || ms_im[cau_pkg::DW];
      end else begin
        pre_re_b_q  <= pre_re_a_q;
        pre_im_b_q  <= pre_im_a_q;
        pre_ovf_b_q <= pre_ovf_a_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: divider setup. The dividend is |n| * 2^FB. Its bits above the
  // quotient field start the remainder; if they already reach the divisor the
  // quotient cannot fit and the part saturates.
  // ---------------------------------------------------------------------------
  logic [cau_pkg::SW-1:0] mag_re, mag_im;
  logic [cau_pkg::NW-1:0] dvd_re, dvd_im;
  logic [cau_pkg::NW-cau_pkg::QB-1:0] hi_re, hi_im;
  cau_pkg::cell_t c0_re_d, c0_im_d;
  cau_pkg::side_t side_c_d;

  always_comb begin
    mag_re = n_re_q[cau_pkg::SW-1] ? -n_re_q : n_re_q;
    mag_im = n_im_q[cau_pkg::SW-1] ? -n_im_q : n_im_q;
    dvd_re = {mag_re, {cau_pkg::FB{1'b0}}};
    dvd_im = {mag_im, {cau_pkg::FB{1'b0}}};
    hi_re  = dvd_re[cau_pkg::NW-1:cau_pkg::QB];
    hi_im  = dvd_im[cau_pkg::NW-1:cau_pkg::QB];

    c0_re_d.rem = cau_pkg::rem_t'(hi_re);
    c0_re_d.low = dvd_re[cau_pkg::QB-1:0];
    c0_re_d.quo = '0;
    c0_re_d.den = den_q;
    c0_im_d.rem = cau_pkg::rem_t'(hi_im);
    c0_im_d.low = dvd_im[cau_pkg::QB-1:0];
    c0_im_d.quo = '0;
    c0_im_d.den = den_q;

    side_c_d.op      = op_b_q;
    side_c_d.pre_re  = pre_re_b_q;
    side_c_d.pre_im  = pre_im_b_q;
    side_c_d.pre_ovf = pre_ovf_b_q;
    side_c_d.dz      = (op_b_q == cau_pkg::OP_DIV) && (den_q == '0);
    side_c_d.neg_re  = n_re_q[cau_pkg::SW-1];
    side_c_d.neg_im  = n_im_q[cau_pkg::SW-1];
    side_c_d.big_re  = cau_pkg::rem_t'(hi_re) >= den_q;
    side_c_d.big_im  = cau_pkg::rem_t'(hi_im) >= den_q;
  end

  // Index 0 of each chain is the setup register; index k+1 is the output of cell k.
  cau_pkg::cell_t c0_re_q, c0_im_q;
  cau_pkg::cell_t re_chain [cau_pkg::QB+1];
  cau_pkg::cell_t im_chain [cau_pkg::QB+1];
  cau_pkg::side_t side_q   [cau_pkg::QB+1];
  logic [cau_pkg::QB:0] v_k_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_re_q   <= c0_re_d;
      c0_im_q   <= c0_im_d;
      side_q[0] <= side_c_d;
      for (int k = 0; k < cau_pkg::QB; k++) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign re_chain[0] = c0_re_q;
  assign im_chain[0] = c0_im_q;

  // ---------------------------------------------------------------------------
  // Divider: one cell per quotient bit for each part, MSB first.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < cau_pkg::QB; k++) begin : g_cell
    cau_div_cell u_re (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (re_chain[k]),
      .cell_o (re_chain[k+1])
    );
    cau_div_cell u_im (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (im_chain[k]),
      .cell_o (im_chain[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: sign the quotients, saturate, and pick the result by operation.
  // ---------------------------------------------------------------------------
  cau_pkg::side_t       sd;
  cau_pkg::sat_t        q_re, q_im;
  logic [cau_pkg::DW:0] qs_re, qs_im;
  cau_pkg::word_t       res_re_d, res_im_d;
  logic                 ovf_d, dz_d;

  always_comb begin
    sd    = side_q[cau_pkg::QB];
    q_re  = cau_pkg::sat_t'({1'b0, re_chain[cau_pkg::QB].quo});
    q_im  = cau_pkg::sat_t'({1'b0, im_chain[cau_pkg::QB].quo});
    q_re  = sd.neg_re ? -q_re : q_re;
    q_im  = sd.neg_im ? -q_im : q_im;
    qs_re = cau_pkg::sat(q_re);
    qs_im = cau_pkg::sat(q_im);
    if (sd.big_re) begin
      qs_re = {1'b1, sd.neg_re ? cau_pkg::W_MIN : cau_pkg::W_MAX};
    end
    if (sd.big_im) begin
      qs_im = {1'b1, sd.neg_im ? cau_pkg::W_MIN : cau_pkg::W_MAX};
    end

    if (sd.op == cau_pkg::OP_DIV) begin
      if (sd.dz) begin
        res_re_d = '0;
        res_im_d = '0;
        ovf_d    = 1'b0;
        dz_d     = 1'b1;
      end else begin
        res_re_d = qs_re[cau_pkg::DW-1:0];
        res_im_d = qs_im[cau_pkg::DW-1:0];
        ovf_d    = qs_re[cau_pkg::DW] || qs_im[cau_pkg::DW];
        dz_d     = 1'b0;
      end
    end else begin
      res_re_d = sd.pre_re;
      res_im_d = sd.pre_im;
      ovf_d    = sd.pre_ovf;
      dz_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_o   <= res_re_d;
      res_im_o   <= res_im_d;
      overflow_o <= ovf_d;
      div_zero_o <= dz_d;
    end
  end

  // Valid bits of every stage, the only state that reset clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q       <= 1'b0;
      v_b_q       <= 1'b0;
      v_k_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_a_q       <= in_valid_i;
      v_b_q       <= v_a_q;
      v_k_q       <= {v_k_q[cau_pkg::QB-1:0], v_b_q};
      out_valid_q <= v_k_q[cau_pkg::QB];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/cau_checker.sv -----
`include "assert_macros.svh"

module cau_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [cau_pkg::DW-1:0] res_re_o,
  input logic signed [cau_pkg::DW-1:0] res_im_o,
  input logic                          overflow_o,
  input logic                          div_zero_o
);

  logic                      dz_clean;
  logic                      re_at_lim;
  logic                      im_at_lim;
  logic                      out_wait;
  logic [2*cau_pkg::DW+1:0]  out_bus;

  assign dz_clean  = !overflow_o && res_re_o == '0 && res_im_o == '0;
  assign re_at_lim = res_re_o == cau_pkg::W_MAX || res_re_o == cau_pkg::W_MIN;
  assign im_at_lim = res_im_o == cau_pkg::W_MAX || res_im_o == cau_pkg::W_MIN;
  assign out_wait  = out_valid_o && !out_ready_i;
  assign out_bus   = {res_re_o, res_im_o, overflow_o, div_zero_o};

  // A zero divisor gives a zero result and never an overflow.
  `CHK_SAME(a_dz_zero, clk_i, rst_ni, out_valid_o && div_zero_o, dz_clean)

  // An overflow always leaves at least one part at a limit of the word.
  `CHK_SAME(a_ovf_limit, clk_i, rst_ni, out_valid_o && overflow_o, re_at_lim || im_at_lim)

  // A waiting result stays offered.
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o)

  // A waiting result does not change.
  `CHK_NEXT(a_out_stable, clk_i, rst_ni, out_wait, $stable(out_bus))

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .res_re_o    (res_re_o),
  .res_im_o    (res_im_o),
  .overflow_o  (overflow_o),
  .div_zero_o  (div_zero_o)
);
